// File: src/lses_pkg.sv
// Shared types, codes and constants for the LED strip effect sequencer.
package lses_pkg;

	// Fixed timing and look constants
	localparam logic [31:0] REFRESH_MS    = 32'd20;
	localparam logic [31:0] BOOT_BLINK_MS = 32'd500;
	localparam logic [23:0] COLOR_WHITE   = 24'hFFFFFF;
	localparam logic [23:0] COLOR_GREEN   = 24'h00FF00;
	localparam logic [23:0] COLOR_BLUE    = 24'h0000FF;

	// Command buffer: at most six commands per tick
	localparam int CMD_DEPTH = 6;
	localparam int CNT_W     = $clog2(CMD_DEPTH + 1);

	// Configuration register indexes
	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_FIRST_LED = 3'd1;
	localparam logic [2:0] REG_LAST_LED  = 3'd2;
	localparam logic [2:0] REG_COLOR     = 3'd3;
	localparam logic [2:0] REG_PERIOD    = 3'd4;
	localparam logic [2:0] REG_DIR_LEFT  = 3'd5;
	localparam logic [2:0] REG_STRIP_LEN = 3'd6;

	// Effect modes
	localparam logic [2:0] MODE_PAINT = 3'd0;
	localparam logic [2:0] MODE_BLINK = 3'd1;
	localparam logic [2:0] MODE_SHIFT = 3'd2;
	localparam logic [2:0] MODE_TURN  = 3'd3;
	localparam logic [2:0] MODE_BOOT  = 3'd4;
	localparam logic [2:0] MODE_READY = 3'd5;
	localparam logic [2:0] MODE_EXIT  = 3'd6;

	// Strip command codes
	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_FILL    = 2'd1,
		OP_REFRESH = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [10:0] fill_start;
		logic signed [10:0] fill_end;
		logic [23:0]        fill_color;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  first_led;
		logic [7:0]  last_led;
		logic [23:0] color;
		logic [15:0] period_ms;
		logic        direction_left;
		logic [8:0]  strip_length;
	} cfg_t;

	typedef struct packed {
		logic [59:0] snap;
		logic        snap_valid;
		logic [31:0] blink_last;
		logic        blink_on;
		logic [31:0] shift_last;
		logic [9:0]  shift_count;
		logic [31:0] refresh_last;
	} fx_state_t;

endpackage

// File: src/lses_plan.sv
// Per-tick command planner: builds the command list and the next effect state.
module lses_plan (
	input  lses_pkg::cfg_t                   cfg,
	input  lses_pkg::fx_state_t              st,
	input  logic [31:0]                      now_ms,
	output lses_pkg::cmd_t                   cmds [lses_pkg::CMD_DEPTH],
	output logic [lses_pkg::CNT_W-1:0]       n_cmds,
	output lses_pkg::fx_state_t              st_nxt
);
	import lses_pkg::*;

	logic [59:0]        snap;
	logic               changed;
	logic signed [12:0] first_s, last_s, size, len_s, len_m1;
	logic signed [12:0] side, size_half, base, base_sel, cnt_s, p;
	logic signed [12:0] step [4];
	logic [31:0]        per, dt_blink, dt_shift, dt_refresh;
	logic [2:0]         parts;
	logic               blink_mode, shift_mode;
	logic signed [12:0] bl_start, bl_end;
	logic [23:0]        bl_color;
	logic [CNT_W-1:0]   n;

	// Zone and turn geometry, all in 13-bit signed
	assign snap      = {cfg.mode, cfg.first_led, cfg.last_led, cfg.color,
		cfg.period_ms, cfg.direction_left};
	assign changed   = !st.snap_valid || (snap != st.snap);
	assign first_s   = {5'b0, cfg.first_led};
	assign last_s    = {5'b0, cfg.last_led};
	assign size      = last_s - first_s;
	assign len_s     = {4'b0, cfg.strip_length};
	assign len_m1    = len_s - 13'sd1;
	assign side      = {6'b0, cfg.strip_length[8:2]};
	// halving truncates toward zero
	assign size_half = (size + $signed({12'b0, size[12]})) >>> 1;
	assign base      = (side >>> 1) - size_half;
	assign step[0]   = '0;
	assign step[1]   = side;
	assign step[2]   = side <<< 1;
	assign step[3]   = (side <<< 1) + side;

	assign n_cmds = n;

	always_comb begin
		for (int i = 0; i < CMD_DEPTH; i++) begin
			cmds[i] = '0;
		end
		n          = '0;
		st_nxt     = st;
		per        = '0;
		dt_blink   = '0;
		dt_shift   = '0;
		dt_refresh = '0;
		parts      = '0;
		base_sel   = '0;
		cnt_s      = '0;
		p          = '0;
		blink_mode = 1'b0;
		shift_mode = 1'b0;
		bl_start   = '0;
		bl_end     = '0;
		bl_color   = '0;

		// New settings: clear strip and restart blink and shift
		if (changed) begin
			st_nxt.snap        = snap;
			st_nxt.snap_valid  = 1'b1;
			st_nxt.blink_last  = '0;
			st_nxt.blink_on    = 1'b0;
			st_nxt.shift_last  = '0;
			st_nxt.shift_count = '0;
			cmds[n].op         = OP_CLEAR;
			n                  = n + 1'b1;
		end

		// Mode selection
		unique case (cfg.mode)
			MODE_PAINT: begin
				cmds[n] = '{OP_FILL, first_s[10:0], last_s[10:0], cfg.color};
				n       = n + 1'b1;
			end
			MODE_BLINK: begin
				blink_mode = 1'b1;
				per        = {16'b0, cfg.period_ms};
				bl_start   = first_s;
				bl_end     = last_s;
				bl_color   = cfg.color;
			end
			MODE_SHIFT: begin
				shift_mode = 1'b1;
				parts      = 3'd1;
				base_sel   = first_s;
			end
			MODE_TURN: begin
				shift_mode = 1'b1;
				parts      = 3'd4;
				base_sel   = base;
			end
			MODE_BOOT: begin
				blink_mode = 1'b1;
				per        = BOOT_BLINK_MS;
				bl_start   = '0;
				bl_end     = len_m1;
				bl_color   = COLOR_WHITE;
			end
			MODE_READY: begin
				cmds[n] = '{OP_FILL, 11'sd0, len_m1[10:0], COLOR_GREEN};
				n       = n + 1'b1;
			end
			MODE_EXIT: begin
				cmds[n] = '{OP_FILL, 11'sd0, len_m1[10:0], COLOR_BLUE};
				n       = n + 1'b1;
			end
			default: begin
			end
		endcase

		// Blink toggle
		dt_blink = now_ms - st_nxt.blink_last;
		if (blink_mode && (dt_blink > per)) begin
			st_nxt.blink_last = now_ms;
			cmds[n] = '{OP_FILL, bl_start[10:0], bl_end[10:0],
				st_nxt.blink_on ? 24'h0 : bl_color};
			st_nxt.blink_on = !st_nxt.blink_on;
			n = n + 1'b1;
		end

		// Growing bar step, one or four parts
		dt_shift = now_ms - st_nxt.shift_last;
		cnt_s    = {3'b0, st_nxt.shift_count};
		if (shift_mode && (dt_shift > {16'b0, cfg.period_ms})) begin
			st_nxt.shift_last = now_ms;
			if (cnt_s <= size) begin
				for (int k = 0; k < 4; k++) begin
					if (3'(k) < parts) begin
						p = base_sel + step[k];
						cmds[n].op         = OP_FILL;
						cmds[n].fill_color = cfg.color;
						if (cfg.direction_left) begin
							cmds[n].fill_start = p[10:0];
							cmds[n].fill_end   = 11'(p + cnt_s);
						end else begin
							cmds[n].fill_start = 11'(p + size - cnt_s);
							cmds[n].fill_end   = 11'(p + size);
						end
						n = n + 1'b1;
					end
				end
				st_nxt.shift_count = st_nxt.shift_count + 10'd1;
			end else begin
				cmds[n] = '{OP_FILL, 11'sd0, len_s[10:0], 24'h0};
				n       = n + 1'b1;
				st_nxt.shift_count = '0;
			end
		end

		// Refresh throttle
		dt_refresh = now_ms - st.refresh_last;
		if (dt_refresh >= REFRESH_MS) begin
			st_nxt.refresh_last = now_ms;
			cmds[n].op          = OP_REFRESH;
			n                   = n + 1'b1;
		end
	end

endmodule

// File: src/led_strip_effect_sequencer.sv
// Top level of the LED strip effect sequencer: config registers, planner, command buffer.
//
//  port group   dir  handshake                payload
//  tick         in   tick_valid / tick_ready  now_ms
//  cmd          out  cmd_valid / cmd_ready    op, fill_start, fill_end, fill_color, last
//  cfg          in   cfg_we (no wait)         cfg_index, cfg_data
//
// A tick is planned in the cycle it is accepted; its commands (zero to six) are
// loaded into a six-entry command buffer and leave one per cycle while cmd_ready
// is high.
// The next tick is accepted in the cycle the last buffered command is taken.
// Reset clears the config registers to their defaults and the effect state.
// A stalled cmd_ready holds the buffer and blocks new ticks.
module led_strip_effect_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick_valid,
	output logic               tick_ready,
	input  logic [31:0]        now_ms,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output logic [1:0]         op,
	output logic signed [10:0] fill_start,
	output logic signed [10:0] fill_end,
	output logic [23:0]        fill_color,
	output logic               last,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import lses_pkg::*;

	cfg_t             cfg_q;
	fx_state_t        st_q, st_nxt;
	cmd_t             plan_cmds [CMD_DEPTH];
	logic [CNT_W-1:0] plan_n;
	cmd_t             buf_q [CMD_DEPTH];
	logic [CNT_W-1:0] cnt_q, rd_q;
	logic             pop, take;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mode: MODE_PAINT, first_led: 8'd0, last_led: 8'd0, color: 24'd0,
				period_ms: 16'd500, direction_left: 1'b0, strip_length: 9'd16};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:      cfg_q.mode           <= cfg_data[2:0];
				REG_FIRST_LED: cfg_q.first_led      <= cfg_data[7:0];
				REG_LAST_LED:  cfg_q.last_led       <= cfg_data[7:0];
				REG_COLOR:     cfg_q.color          <= cfg_data;
				REG_PERIOD:    cfg_q.period_ms      <= cfg_data[15:0];
				REG_DIR_LEFT:  cfg_q.direction_left <= cfg_data[0];
				REG_STRIP_LEN: cfg_q.strip_length   <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	lses_plan u_plan (
		.cfg    (cfg_q),
		.st     (st_q),
		.now_ms (now_ms),
		.cmds   (plan_cmds),
		.n_cmds (plan_n),
		.st_nxt (st_nxt)
	);

	// Handshake
	assign cmd_valid  = (rd_q != cnt_q);
	assign pop        = cmd_valid && cmd_ready;
	assign tick_ready = !cmd_valid || (pop && (rd_q + 1'b1 == cnt_q));
	assign take       = tick_valid && tick_ready;

	// Effect state and buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (take) begin
			st_q  <= st_nxt;
			cnt_q <= plan_n;
			rd_q  <= '0;
		end else if (pop) begin
			rd_q <= rd_q + 1'b1;
		end
	end

	// Command buffer payload
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < CMD_DEPTH; i++) begin
				buf_q[i] <= plan_cmds[i];
			end
		end
	end

	// Output fields
	assign op         = buf_q[rd_q].op;
	assign fill_start = buf_q[rd_q].fill_start;
	assign fill_end   = buf_q[rd_q].fill_end;
	assign fill_color = buf_q[rd_q].fill_color;
	assign last       = (rd_q + 1'b1 == cnt_q);

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the LED strip effect sequencer: table-driven and random ticks.
`timescale 1ns / 100ps

module tb_top;
	import lses_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_TICKS   = 500;
	localparam int DRAIN_CYCLES = 4;
	localparam int TURN_PARTS   = 4;

	// Codes with no effect or register behind them
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam logic [2:0] REG_UNUSED  = 3'd7;

	typedef struct packed {
		op_t                op;
		logic signed [10:0] fill_start;
		logic signed [10:0] fill_end;
		logic [23:0]        fill_color;
		logic               last;
	} strip_cmd_t;

	// One row of the directed table: a register write or a tick
	typedef struct {
		bit          wr;
		logic [2:0]  idx;
		logic [23:0] data;
		logic [31:0] now;
		int          n_typed;   // < 0: commands come from the effect planner
		strip_cmd_t  typed [3];
	} step_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               tick_valid = 1'b0;
	logic               tick_ready;
	logic [31:0]        now_ms = '0;
	logic               cmd_valid;
	logic               cmd_ready = 1'b0;
	logic [1:0]         op;
	logic signed [10:0] fill_start;
	logic signed [10:0] fill_end;
	logic [23:0]        fill_color;
	logic               last;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [23:0]        cfg_data = '0;

	// Register copy and effect state of the planner
	cfg_t        regs;
	logic [59:0] look_snap = '0;
	bit          look_snap_ok = 1'b0;
	logic [31:0] blink_t = '0;
	bit          blink_lit = 1'b0;
	logic [31:0] bar_t = '0;
	logic [9:0]  bar_len = '0;
	logic [31:0] refresh_t = '0;

	strip_cmd_t tick_cmds[$];
	strip_cmd_t pending_cmds[$];
	step_row_t  dir_rows[$];
	logic [31:0] clock_ms = '0;
	bit          calm = 1'b0;
	int          fails = 0;
	int          cycles = 0;

	led_strip_effect_sequencer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.now_ms     (now_ms),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.op         (op),
		.fill_start (fill_start),
		.fill_end   (fill_end),
		.fill_color (fill_color),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic strip_cmd_t mk_cmd(op_t o, int s, int e, logic [23:0] c, logic l);
		strip_cmd_t k;
		k.op = o;
		k.fill_start = 11'(s);
		k.fill_end = 11'(e);
		k.fill_color = c;
		k.last = l;
		return k;
	endfunction

	function automatic void add_cmd(op_t o, int s, int e, logic [23:0] c);
		tick_cmds.push_back(mk_cmd(o, s, e, c, 1'b0));
	endfunction

	// Toggle between lit and dark once the period has run out
	function automatic void plan_blink(logic [31:0] t, int s, int e, logic [23:0] c,
			logic [31:0] per);
		if (t - blink_t > per) begin
			blink_t = t;
			add_cmd(OP_FILL, s, e, blink_lit ? 24'h0 : c);
			blink_lit = !blink_lit;
		end
	endfunction

	// Growing bar, one or more parts; past the zone size it blanks and restarts
	function automatic void plan_bar(logic [31:0] t, int base, int step, int parts, int size);
		int k, p, cnt;
		if (t - bar_t > {16'd0, regs.period_ms}) begin
			bar_t = t;
			cnt = int'(bar_len);
			if (cnt <= size) begin
				for (k = 0; k < parts; k++) begin
					p = base + step * k;
					if (regs.direction_left)
						add_cmd(OP_FILL, p, p + cnt, regs.color);
					else
						add_cmd(OP_FILL, p + size - cnt, p + size, regs.color);
				end
				bar_len = bar_len + 10'd1;
			end else begin
				add_cmd(OP_FILL, 0, int'(regs.strip_length), 24'h0);
				bar_len = '0;
			end
		end
	endfunction

	// Work out the commands of one tick into tick_cmds and advance the effect state
	function automatic void plan_tick(logic [31:0] t);
		logic [59:0] snap;
		int size, len, side, base;
		strip_cmd_t k;
		tick_cmds.delete();
		size = int'(regs.last_led) - int'(regs.first_led);
		len = int'(regs.strip_length);
		snap = {regs.mode, regs.first_led, regs.last_led, regs.color, regs.period_ms,
			regs.direction_left};
		if (!look_snap_ok || snap != look_snap) begin
			look_snap = snap;
			look_snap_ok = 1'b1;
			add_cmd(OP_CLEAR, 0, 0, 24'h0);
			blink_t = '0;
			blink_lit = 1'b0;
			bar_t = '0;
			bar_len = '0;
		end
		case (regs.mode)
			MODE_PAINT: add_cmd(OP_FILL, int'(regs.first_led), int'(regs.last_led), regs.color);
			MODE_BLINK: plan_blink(t, int'(regs.first_led), int'(regs.last_led), regs.color,
				{16'd0, regs.period_ms});
			MODE_SHIFT: plan_bar(t, int'(regs.first_led), 0, 1, size);
			MODE_TURN: begin
				side = len / TURN_PARTS;
				base = side / 2 - size / 2;
				plan_bar(t, base, side, TURN_PARTS, size);
			end
			MODE_BOOT: plan_blink(t, 0, len - 1, COLOR_WHITE, BOOT_BLINK_MS);
			MODE_READY: add_cmd(OP_FILL, 0, len - 1, COLOR_GREEN);
			MODE_EXIT: add_cmd(OP_FILL, 0, len - 1, COLOR_BLUE);
			default: ;
		endcase
		if (t - refresh_t >= REFRESH_MS) begin
			refresh_t = t;
			add_cmd(OP_REFRESH, 0, 0, 24'h0);
		end
		if (tick_cmds.size() > 0) begin
			k = tick_cmds.pop_back();
			k.last = 1'b1;
			tick_cmds.push_back(k);
		end
	endfunction

	// Directed table builders
	function automatic void add_write(logic [2:0] i, logic [23:0] d);
		step_row_t r;
		r.wr = 1'b1;
		r.idx = i;
		r.data = d;
		r.now = '0;
		r.n_typed = -1;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_typed(logic [31:0] t, int n, strip_cmd_t c0, strip_cmd_t c1,
			strip_cmd_t c2);
		step_row_t r;
		r.wr = 1'b0;
		r.idx = '0;
		r.data = '0;
		r.now = t;
		r.n_typed = n;
		r.typed[0] = c0;
		r.typed[1] = c1;
		r.typed[2] = c2;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_tick(logic [31:0] t);
		add_typed(t, -1, '0, '0, '0);
	endfunction

	// Random junk above the register's own bits, some of the time
	function automatic logic [23:0] with_junk(logic [23:0] v, logic [23:0] mask);
		logic [23:0] j;
		j = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'h0;
		return (v & mask) | (j & ~mask);
	endfunction

	task automatic write_reg(input logic [2:0] i, input logic [23:0] d);
		cfg_we <= 1'b1;
		cfg_index <= i;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (i)
			REG_MODE:      regs.mode = d[2:0];
			REG_FIRST_LED: regs.first_led = d[7:0];
			REG_LAST_LED:  regs.last_led = d[7:0];
			REG_COLOR:     regs.color = d;
			REG_PERIOD:    regs.period_ms = d[15:0];
			REG_DIR_LEFT:  regs.direction_left = d[0];
			REG_STRIP_LEN: regs.strip_length = d[8:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one tick, with a random gap first; valid stays up after acceptance
	task automatic send_tick(input logic [31:0] t);
		if (!calm && $urandom_range(0, 99) < 21) begin
			tick_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 21);
		end
		tick_valid <= 1'b1;
		now_ms <= t;
		do @(posedge clk); while (!tick_ready);
	endtask

	task automatic run_tick(input logic [31:0] t);
		plan_tick(t);
		foreach (tick_cmds[k])
			pending_cmds.push_back(tick_cmds[k]);
		send_tick(t);
	endtask

	// Wait until the block is idle: all commands out, plus a no-command tick in flight
	task automatic settle();
		tick_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic log_bad(input string what, input strip_cmd_t want, input strip_cmd_t got);
		fails++;
		if (fails <= 10)
			$display("%s: want op=%0d start=%0d end=%0d color=%06h last=%0b,", what,
				want.op, want.fill_start, want.fill_end, want.fill_color, want.last,
				" got op=%0d start=%0d end=%0d color=%06h last=%0b",
				got.op, got.fill_start, got.fill_end, got.fill_color, got.last);
	endtask

	// Command side: check each taken command, then pick the next ready
	always @(posedge clk) begin : cmd_check
		strip_cmd_t got, want;
		if (arst_n && cmd_valid && cmd_ready) begin
			got.op = op_t'(op);
			got.fill_start = fill_start;
			got.fill_end = fill_end;
			got.fill_color = fill_color;
			got.last = last;
			if (pending_cmds.size() == 0) begin
				log_bad("unexpected command", '0, got);
			end else begin
				want = pending_cmds.pop_front();
				if (got.op !== want.op || got.fill_start !== want.fill_start ||
						got.fill_end !== want.fill_end || got.fill_color !== want.fill_color ||
						got.last !== want.last)
					log_bad("command mismatch", want, got);
			end
		end
		cmd_ready <= calm || ($urandom_range(0, 99) >= 21);
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		int j, n_rand, burst, pick, a, b;
		logic [23:0] v;

		regs.mode = MODE_PAINT;
		regs.first_led = '0;
		regs.last_led = '0;
		regs.color = '0;
		regs.period_ms = 16'd500;
		regs.direction_left = 1'b0;
		regs.strip_length = 9'd16;

		// Directed table: defaults after reset, the fixed looks, strip extremes
		add_typed(32'd0, 2, mk_cmd(OP_CLEAR, 0, 0, 24'h0, 1'b0),
			mk_cmd(OP_FILL, 0, 0, 24'h0, 1'b1), '0);
		add_typed(32'd20, 2, mk_cmd(OP_FILL, 0, 0, 24'h0, 1'b0),
			mk_cmd(OP_REFRESH, 0, 0, 24'h0, 1'b1), '0);
		add_write(REG_COLOR, 24'hFFFFFF);
		add_write(REG_LAST_LED, 24'd255);
		add_tick(32'd25);
		add_write(REG_MODE, {21'd0, MODE_READY});
		add_typed(32'd40, 3, mk_cmd(OP_CLEAR, 0, 0, 24'h0, 1'b0),
			mk_cmd(OP_FILL, 0, 15, COLOR_GREEN, 1'b0), mk_cmd(OP_REFRESH, 0, 0, 24'h0, 1'b1));
		add_write(REG_MODE, {21'd0, MODE_EXIT});
		add_write(REG_STRIP_LEN, 24'd256);
		add_typed(32'd41, 2, mk_cmd(OP_CLEAR, 0, 0, 24'h0, 1'b0),
			mk_cmd(OP_FILL, 0, 255, COLOR_BLUE, 1'b1), '0);
		// strip length zero: end of range at -1
		add_write(REG_STRIP_LEN, 24'd0);
		add_typed(32'd42, 1, mk_cmd(OP_FILL, 0, -1, COLOR_BLUE, 1'b1), '0, '0);
		// unused mode and an index with no register behind it
		add_write(REG_UNUSED, 24'hA5A5A5);
		add_write(REG_MODE, {21'd0, MODE_UNUSED});
		add_typed(32'd60, 2, mk_cmd(OP_CLEAR, 0, 0, 24'h0, 1'b0),
			mk_cmd(OP_REFRESH, 0, 0, 24'h0, 1'b1), '0);
		add_typed(32'd61, 0, '0, '0, '0);
		// blink with period zero, then the longest period and a time wrap
		add_write(REG_MODE, {21'd0, MODE_BLINK});
		add_write(REG_STRIP_LEN, 24'd16);
		add_write(REG_PERIOD, 24'd0);
		add_write(REG_FIRST_LED, 24'd3);
		add_write(REG_LAST_LED, 24'd10);
		add_write(REG_COLOR, 24'h123456);
		add_tick(32'd100);
		add_tick(32'd100);
		add_tick(32'd101);
		add_write(REG_PERIOD, 24'hFFFF);
		add_tick(32'd200);
		add_tick(32'hFFFF_FFFF);
		add_write(REG_MODE, {21'd0, MODE_BOOT});
		add_tick(32'd1000);
		add_tick(32'd1600);
		// bar grows from the start, wraps to a blank, then grows from the end
		add_write(REG_MODE, {21'd0, MODE_SHIFT});
		add_write(REG_FIRST_LED, 24'd2);
		add_write(REG_LAST_LED, 24'd5);
		add_write(REG_PERIOD, 24'd0);
		add_write(REG_DIR_LEFT, 24'd1);
		for (j = 0; j < 6; j++)
			add_tick(32'd2000 + 32'(j));
		add_write(REG_DIR_LEFT, 24'd0);
		add_tick(32'd2010);
		// turn with a reversed zone only blanks
		add_write(REG_MODE, {21'd0, MODE_TURN});
		add_write(REG_FIRST_LED, 24'd10);
		add_write(REG_LAST_LED, 24'd6);
		add_tick(32'd2020);
		// turn across the widest zone and strip
		add_write(REG_FIRST_LED, 24'd0);
		add_write(REG_LAST_LED, 24'd255);
		add_write(REG_STRIP_LEN, 24'd256);
		add_tick(32'd2030);
		add_tick(32'd2031);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].wr) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else if (dir_rows[i].n_typed < 0) begin
				run_tick(dir_rows[i].now);
			end else begin
				// keep the planner state in step; the row holds the expectation
				plan_tick(dir_rows[i].now);
				for (j = 0; j < dir_rows[i].n_typed; j++)
					pending_cmds.push_back(dir_rows[i].typed[j]);
				send_tick(dir_rows[i].now);
			end
		end
		clock_ms = 32'd2031;

		// Random phases: new settings while idle, then a burst of ticks
		n_rand = 0;
		while (n_rand < RAND_TICKS) begin
			settle();
			if ($urandom_range(0, 99) < 70) begin
				pick = $urandom_range(0, 9);
				v = (pick == 8) ? {21'd0, MODE_SHIFT} :
					(pick == 9) ? {21'd0, MODE_TURN} : 24'(pick);
				write_reg(REG_MODE, with_junk(v, 24'h7));
			end
			if ($urandom_range(0, 99) < 60) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					a = $urandom_range(0, 60);
					b = a + $urandom_range(0, 8);
				end else if (pick < 75) begin
					b = $urandom_range(0, 60);
					a = b + $urandom_range(1, 8);
				end else if (pick < 90) begin
					a = $urandom_range(0, 255);
					b = $urandom_range(0, 255);
				end else begin
					a = $urandom_range(0, 1) * 255;
					b = $urandom_range(0, 1) * 255;
				end
				write_reg(REG_FIRST_LED, with_junk(24'(a), 24'hFF));
				write_reg(REG_LAST_LED, with_junk(24'(b), 24'hFF));
			end
			if ($urandom_range(0, 99) < 40) begin
				pick = $urandom_range(0, 99);
				v = (pick < 10) ? 24'h0 : (pick < 20) ? 24'hFFFFFF : 24'($urandom);
				write_reg(REG_COLOR, v);
			end
			if ($urandom_range(0, 99) < 50) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					v = 24'($urandom_range(0, 12));
				else if (pick < 90)
					v = 24'($urandom_range(13, 300));
				else
					v = $urandom_range(0, 1) ? 24'hFFFF : 24'h0;
				write_reg(REG_PERIOD, with_junk(v, 24'hFFFF));
			end
			if ($urandom_range(0, 99) < 40)
				write_reg(REG_DIR_LEFT, with_junk(24'($urandom_range(0, 1)), 24'h1));
			if ($urandom_range(0, 99) < 40) begin
				pick = $urandom_range(0, 99);
				if (pick < 65)
					v = 24'($urandom_range(1, 64));
				else if (pick < 80)
					v = 24'($urandom_range(65, 256));
				else if (pick < 90)
					v = 24'($urandom_range(257, 511));
				else
					v = (pick < 94) ? 24'd0 : (pick < 97) ? 24'd256 : 24'd511;
				write_reg(REG_STRIP_LEN, with_junk(v, 24'h1FF));
			end
			if ($urandom_range(0, 99) < 5)
				write_reg(REG_UNUSED, 24'($urandom));

			burst = $urandom_range(5, 40);
			repeat (burst) begin
				// a stretch with no stalls on either side
				calm <= (n_rand >= 200 && n_rand < 300);
				pick = $urandom_range(0, 99);
				if (pick < 70)
					clock_ms += $urandom_range(0, (regs.mode == MODE_BOOT) ? 520 :
						(regs.period_ms <= 40) ? int'(regs.period_ms) + 3 : 25);
				else if (pick < 92)
					clock_ms += $urandom_range(0, int'(regs.period_ms) + 520);
				else
					clock_ms = $urandom;
				run_tick(clock_ms);
				n_rand++;
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
